// ===== design/utf8_sanitizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_sanitizer_core assertion macros
// Shared property wrappers for the sanitizer checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_CORE_MACROS_SVH
`define UTF8_SANITIZER_CORE_MACROS_SVH

// checked only outside reset
`define UTF8S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define UTF8S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/utf8s_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types and constants shared by the UTF-8 sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  localparam int LIT_MAX = 4;

  // one decoded input step: rep_cnt U+FFFD marks, then lit_cnt literal bytes
  typedef struct packed {
    logic                     last;
    logic [2:0]               rep_cnt;
    logic [2:0]               lit_cnt;
    logic [LIT_MAX-1:0][7:0]  lits;
  } cmd_t;

  localparam logic [7:0] RPL_B0 = 8'hEF;
  localparam logic [7:0] RPL_B1 = 8'hBF;
  localparam logic [7:0] RPL_B2 = 8'hBD;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN2     = 3'd2;
  localparam logic [2:0] LEN3     = 3'd3;
  localparam logic [2:0] LEN4     = 3'd4;

  localparam logic [20:0] CP_MIN2 = 21'h00080;
  localparam logic [20:0] CP_MIN3 = 21'h00800;
  localparam logic [20:0] CP_MIN4 = 21'h10000;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h0D800;
  localparam logic [20:0] SURR_HI = 21'h0DFFF;

endpackage

// ===== design/utf8_sanitizer_core.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer_core
// UTF-8 byte stream sanitizer: malformed bytes become U+FFFD (EF BF BD).
// ----------------------------------------------------------------------------
// Input channel s_*: one raw byte per beat, s_tlast on the final byte of a
// stream. Output channel m_*: sanitized bytes; m_tlast closes the bytes
// caused by one input beat, m_tuser flags stream end and replacement bytes.
// Input beats that only extend an open sequence give no output beats.
// Path: an input byte's command is registered in the queue, then in the
// expander, then in the output stage. Throughput: one input byte per cycle
// while the command queue has room; the expander sends one output byte per
// cycle while m_tready is high and keeps a command until its N bytes (N up
// to 12) are sent. The queue of QUEUE_DEPTH commands absorbs those bursts.
// Reset clears the sequence state, the queue and the output stage; the
// next byte starts a new stream. When m_tready is low the output beat
// holds, the expander stops, and s_tready drops once the queue fills.
// ----------------------------------------------------------------------------
module utf8_sanitizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] stream_end, [1] is_replacement
);
  import utf8s_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready;
  logic q_valid, q_ready;

  utf8s_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .stream_last (s_tlast),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  utf8s_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  utf8s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== design/utf8s_front.sv =====
// ----------------------------------------------------------------------------
// utf8s_front
// Accepts input bytes, tracks the open sequence and emits one command per
// byte that produces output.
// ----------------------------------------------------------------------------
module utf8s_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              stream_last,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output utf8s_pkg::cmd_t   cmd
);
  import utf8s_pkg::*;

  logic [2:0]  exp_len, exp_len_next;
  logic [1:0]  held_count, held_count_next;
  logic [20:0] code_accum, code_accum_next;
  logic [7:0]  held_bytes [3];

  logic [20:0] acc_ext;
  logic        fresh;
  logic        hold_en;
  logic [1:0]  hold_idx;
  logic [2:0]  rep;
  logic [2:0]  lit_cnt;
  logic [LIT_MAX-1:0][7:0] lits;
  logic        accept;

  function automatic logic seq_ok(input logic [2:0] len, input logic [20:0] cp);
    logic ok;
    ok = 1'b1;
    if (len == LEN2 && cp < CP_MIN2) ok = 1'b0;
    if (len == LEN3 && cp < CP_MIN3) ok = 1'b0;
    if (len == LEN4 && cp < CP_MIN4) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
    return ok;
  endfunction

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;
  assign acc_ext  = {code_accum[14:0], in_byte[5:0]};

  always_comb begin
    exp_len_next    = exp_len;
    held_count_next = held_count;
    code_accum_next = code_accum;
    fresh           = 1'b1;
    hold_en         = 1'b0;
    hold_idx        = held_count;
    rep             = 3'd0;
    lit_cnt         = 3'd0;
    lits            = '0;

    if (exp_len != LEN_NONE) begin
      if (in_byte[7:6] == 2'b10) begin
        fresh           = 1'b0;
        code_accum_next = acc_ext;
        if (({1'b0, held_count} + 3'd1) >= exp_len) begin
          if (seq_ok(exp_len, acc_ext)) begin
            lit_cnt = {1'b0, held_count} + 3'd1;
            lits[0] = held_bytes[0];
            lits[1] = (held_count > 2'd1) ? held_bytes[1] : in_byte;
            lits[2] = (held_count > 2'd2) ? held_bytes[2] : in_byte;
            lits[3] = in_byte;
          end else begin
            rep = {1'b0, held_count} + 3'd1;
          end
          exp_len_next    = LEN_NONE;
          held_count_next = 2'd0;
          code_accum_next = '0;
        end else begin
          hold_en         = 1'b1;
          held_count_next = held_count + 2'd1;
        end
      end else begin
        rep             = {1'b0, held_count};
        exp_len_next    = LEN_NONE;
        held_count_next = 2'd0;
        code_accum_next = '0;
      end
    end

    if (fresh) begin
      if (!in_byte[7]) begin
        lit_cnt = 3'd1;
        lits[0] = in_byte;
      end else if (in_byte[7:5] == 3'b110) begin
        exp_len_next    = LEN2;
        code_accum_next = {16'd0, in_byte[4:0]};
        hold_en         = 1'b1;
        hold_idx        = 2'd0;
        held_count_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        exp_len_next    = LEN3;
        code_accum_next = {17'd0, in_byte[3:0]};
        hold_en         = 1'b1;
        hold_idx        = 2'd0;
        held_count_next = 2'd1;
      end else if (in_byte[7:3] == 5'b11110) begin
        exp_len_next    = LEN4;
        code_accum_next = {18'd0, in_byte[2:0]};
        hold_en         = 1'b1;
        hold_idx        = 2'd0;
        held_count_next = 2'd1;
      end else begin
        rep = rep + 3'd1;
      end
    end

    if (stream_last) begin
      rep             = rep + {1'b0, held_count_next};
      exp_len_next    = LEN_NONE;
      held_count_next = 2'd0;
      code_accum_next = '0;
    end
  end

  assign cmd_valid   = accept && (rep != 3'd0 || lit_cnt != 3'd0);
  assign cmd.last    = stream_last;
  assign cmd.rep_cnt = rep;
  assign cmd.lit_cnt = lit_cnt;
  assign cmd.lits    = lits;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len    <= LEN_NONE;
      held_count <= 2'd0;
      code_accum <= '0;
    end else if (accept) begin
      exp_len    <= exp_len_next;
      held_count <= held_count_next;
      code_accum <= code_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_en) begin
      held_bytes[hold_idx] <= in_byte;
    end
  end

endmodule

// ===== design/utf8s_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8s_fifo
// Short command queue between the classifier and the byte expander.
// ----------------------------------------------------------------------------
module utf8s_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  utf8s_pkg::cmd_t   in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output utf8s_pkg::cmd_t   out_cmd
);
  import utf8s_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== design/utf8s_back.sv =====
// ----------------------------------------------------------------------------
// utf8s_back
// Expands queued commands into output beats, one byte per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module utf8s_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  utf8s_pkg::cmd_t   cmd,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser
);
  import utf8s_pkg::*;

  typedef enum logic [1:0] {SUB_B0, SUB_B1, SUB_B2} rpl_sub_t;

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] rep_left;
  rpl_sub_t   sub;
  logic [1:0] lit_idx;

  logic       out_free, emit, done, take;
  logic [7:0] rpl_byte, emit_byte;
  logic       byte_final;

  always_comb begin
    case (sub)
      SUB_B0:  rpl_byte = RPL_B0;
      SUB_B1:  rpl_byte = RPL_B1;
      SUB_B2:  rpl_byte = RPL_B2;
      default: rpl_byte = RPL_B2;
    endcase
  end

  always_comb begin
    if (rep_left != 3'd0) begin
      emit_byte  = rpl_byte;
      byte_final = (rep_left == 3'd1) && (sub == SUB_B2) && (cur.lit_cnt == 3'd0);
    end else begin
      emit_byte  = cur.lits[lit_idx];
      byte_final = (({1'b0, lit_idx} + 3'd1) == cur.lit_cnt);
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign emit      = cur_valid && out_free;
  assign done      = emit && byte_final;
  assign take      = cmd_valid && (!cur_valid || done);
  assign cmd_ready = !cur_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rep_left  <= 3'd0;
      sub       <= SUB_B0;
      lit_idx   <= 2'd0;
      m_tvalid  <= 1'b0;
    end else begin
      if (take) begin
        cur_valid <= 1'b1;
        rep_left  <= cmd.rep_cnt;
        sub       <= SUB_B0;
        lit_idx   <= 2'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        if (rep_left != 3'd0) begin
          case (sub)
            SUB_B0:  sub <= SUB_B1;
            SUB_B1:  sub <= SUB_B2;
            default: begin
              sub      <= SUB_B0;
              rep_left <= rep_left - 3'd1;
            end
          endcase
        end else begin
          lit_idx <= lit_idx + 2'd1;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
    if (emit) begin
      m_tdata    <= emit_byte;
      m_tlast    <= byte_final;
      m_tuser[0] <= byte_final && cur.last;
      m_tuser[1] <= (rep_left != 3'd0);
    end
  end

endmodule

// ===== design/utf8s_checker.sv =====
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level assertions for utf8_sanitizer_core, attached by bind.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_core_macros.svh"

module utf8s_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);
  import utf8s_pkg::*;

  `UTF8S_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "output beat right after reset")

  `UTF8S_ASSERT(a_end_last, m_tvalid && m_tuser[0] |-> m_tlast, "stream end without run last")

  `UTF8S_ASSERT(a_rpl_byte, m_tvalid && m_tuser[1] |-> (m_tdata == RPL_B0 || m_tdata == RPL_B1 || m_tdata == RPL_B2), "bad replacement byte")

  `UTF8S_ASSERT(a_rpl_split, m_tvalid && m_tuser[1] && m_tdata == RPL_B0 |-> !m_tlast, "replacement split by run last")

  `UTF8S_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

endmodule

bind utf8_sanitizer_core utf8s_checker u_utf8s_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
